FILE: sv/dns_name_text_to_wire_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the DNS name text-to-wire block
// Each macro samples on clk_i and is disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef DNS_NAME_TEXT_TO_WIRE_TOP_MACROS_SVH
`define DNS_NAME_TEXT_TO_WIRE_TOP_MACROS_SVH

// Same-cycle check: prop must hold at every clock edge.
`define DNTW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Next-cycle check: when ante holds, cons must hold in the following cycle.
`define DNTW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/dntw_pkg.sv
// ----------------------------------------------------------------------------
// dntw_pkg
// Shared types and constants for the DNS name text-to-wire converter.
// ----------------------------------------------------------------------------
`default_nettype none

package dntw_pkg;

  // Longest wire-format name, in bytes
  localparam logic [7:0] MAX_NAME_BYTES = 8'd255;

  // Character codes
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_DOT       = 8'h2E;
  localparam logic [7:0] CH_UPPER_A   = 8'h41;
  localparam logic [7:0] CH_UPPER_Z   = 8'h5A;
  localparam logic [7:0] CH_DIGIT_0   = 8'h30;
  localparam logic [7:0] CH_DIGIT_9   = 8'h39;
  localparam logic [7:0] CH_NUL       = 8'h00;
  localparam logic [7:0] CASE_BIT     = 8'h20;

  // Completion status reported on the last item of a name
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_PARSE    = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_e;

  // One output item
  typedef struct packed {
    logic       we;
    logic [7:0] offset;
    logic [7:0] wbyte;
    logic       last;
    status_e    status;
    logic [7:0] name_len;
  } result_t;

  // Items produced by one input item (count is 0, 1 or 2)
  typedef struct packed {
    logic [1:0] count;
    result_t    r0;
    result_t    r1;
  } parse_out_t;

endpackage

`default_nettype wire

FILE: sv/dntw_parse.sv
// ----------------------------------------------------------------------------
// dntw_parse
// Parse state and combinational next-state logic; one character per fire.
// ----------------------------------------------------------------------------
`default_nettype none

module dntw_parse (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    fire_i,
  input  wire  [7:0]             char_i,
  input  wire                    eon_i,
  output dntw_pkg::parse_out_t   res_o
);
  import dntw_pkg::*;
  `include "dns_name_text_to_wire_top_macros.svh"

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_ESCAPE = 2'd1,
    MODE_DIGIT1 = 2'd2,
    MODE_DIGIT2 = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    TRK_NONE = 2'd0,
    TRK_DOT  = 2'd1,
    TRK_MORE = 2'd2
  } trk_e;

  mode_e       mode_q, mode_d;
  trk_e        trk_q, trk_d;
  status_e     err_q, err_d;
  logic [9:0]  acc_q, acc_d;
  logic [7:0]  lstart_q, lstart_d;
  logic [7:0]  llen_q, llen_d;
  logic [7:0]  used_q, used_d;
  logic        pend_q, pend_d;

  logic [7:0]  bu;
  logic        is_digit;
  logic [3:0]  digit;
  logic [13:0] acc_sum;
  result_t     wr_item;
  parse_out_t  res;

  // Decode the character
  assign is_digit = (char_i >= CH_DIGIT_0) && (char_i <= CH_DIGIT_9);
  assign digit    = 4'(char_i - CH_DIGIT_0);
  assign acc_sum  = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + {10'd0, digit};

  // Count the reserved length slot once the next label starts
  assign bu = pend_q ? 8'(used_q + 8'd1) : used_q;

  // Next state and produced items
  always_comb begin
    mode_d   = mode_q;
    trk_d    = trk_q;
    err_d    = err_q;
    acc_d    = acc_q;
    lstart_d = lstart_q;
    llen_d   = llen_q;
    used_d   = used_q;
    pend_d   = pend_q;
    res      = '0;
    wr_item  = '0;
    wr_item.we = 1'b1;

    if (eon_i) begin
      // Close the name and return to the reset state
      res.count   = 2'd1;
      res.r0.last = 1'b1;
      if (err_q != ST_OK) begin
        res.r0.status = err_q;
      end else if (trk_q == TRK_DOT) begin
        res.r0.we       = 1'b1;
        res.r0.name_len = 8'd1;
      end else if ((trk_q == TRK_NONE) || (mode_q != MODE_NORMAL)) begin
        res.r0.status = ST_PARSE;
      end else if (used_q >= MAX_NAME_BYTES) begin
        res.r0.status = ST_OVERFLOW;
      end else if (pend_q) begin
        res.r0.we       = 1'b1;
        res.r0.offset   = lstart_q;
        res.r0.name_len = 8'(used_q + 8'd1);
      end else begin
        res.count       = 2'd2;
        res.r0.we       = 1'b1;
        res.r0.offset   = lstart_q;
        res.r0.wbyte    = llen_q;
        res.r0.last     = 1'b0;
        res.r1.we       = 1'b1;
        res.r1.offset   = used_q;
        res.r1.last     = 1'b1;
        res.r1.name_len = 8'(used_q + 8'd1);
      end
      mode_d   = MODE_NORMAL;
      trk_d    = TRK_NONE;
      err_d    = ST_OK;
      acc_d    = '0;
      lstart_d = '0;
      llen_d   = '0;
      used_d   = 8'd1;
      pend_d   = 1'b0;
    end else if (err_q != ST_OK) begin
      // Ignore everything until the end marker
    end else if (trk_q == TRK_DOT) begin
      err_d = ST_PARSE;
    end else begin
      case (mode_q)
        MODE_NORMAL: begin
          used_d = bu;
          pend_d = 1'b0;
          wr_item.offset = bu;
          if (bu >= MAX_NAME_BYTES) begin
            err_d = ST_OVERFLOW;
          end else if ((trk_q == TRK_NONE) && (char_i == CH_DOT)) begin
            trk_d = TRK_DOT;
          end else begin
            trk_d = TRK_MORE;
            if (char_i == CH_NUL) begin
              err_d = ST_PARSE;
            end else if (char_i == CH_BACKSLASH) begin
              mode_d = MODE_ESCAPE;
            end else if (char_i == CH_DOT) begin
              if (llen_q == 8'd0) begin
                err_d = ST_PARSE;
              end else begin
                res.count     = 2'd1;
                res.r0.we     = 1'b1;
                res.r0.offset = lstart_q;
                res.r0.wbyte  = llen_q;
                lstart_d      = bu;
                pend_d        = 1'b1;
                llen_d        = 8'd0;
              end
            end else begin
              res.count = 2'd1;
              res.r0    = wr_item;
              if ((char_i >= CH_UPPER_A) && (char_i <= CH_UPPER_Z)) begin
                res.r0.wbyte = char_i | CASE_BIT;
              end else begin
                res.r0.wbyte = char_i;
              end
              used_d = 8'(bu + 8'd1);
              llen_d = 8'(llen_q + 8'd1);
            end
          end
        end
        MODE_ESCAPE: begin
          if (is_digit) begin
            acc_d  = {6'd0, digit};
            mode_d = MODE_DIGIT1;
          end else if (char_i == CH_NUL) begin
            err_d = ST_PARSE;
          end else begin
            mode_d         = MODE_NORMAL;
            res.count      = 2'd1;
            res.r0         = wr_item;
            res.r0.offset  = used_q;
            res.r0.wbyte   = char_i;
            used_d         = 8'(used_q + 8'd1);
            llen_d         = 8'(llen_q + 8'd1);
          end
        end
        MODE_DIGIT1: begin
          if (!is_digit) begin
            err_d = ST_PARSE;
          end else begin
            acc_d  = acc_sum[9:0];
            mode_d = MODE_DIGIT2;
          end
        end
        default: begin
          if (!is_digit) begin
            err_d = ST_PARSE;
          end else begin
            acc_d = acc_sum[9:0];
            if (acc_sum[13:8] != 6'd0) begin
              err_d = ST_PARSE;
            end else begin
              mode_d        = MODE_NORMAL;
              res.count     = 2'd1;
              res.r0        = wr_item;
              res.r0.offset = used_q;
              res.r0.wbyte  = acc_sum[7:0];
              used_d        = 8'(used_q + 8'd1);
              llen_d        = 8'(llen_q + 8'd1);
            end
          end
        end
      endcase
    end
  end

  assign res_o = res;

  // Hold parse state; advance on each fired item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_NORMAL;
      trk_q    <= TRK_NONE;
      err_q    <= ST_OK;
      acc_q    <= '0;
      lstart_q <= '0;
      llen_q   <= '0;
      used_q   <= 8'd1;
      pend_q   <= 1'b0;
    end else if (fire_i) begin
      mode_q   <= mode_d;
      trk_q    <= trk_d;
      err_q    <= err_d;
      acc_q    <= acc_d;
      lstart_q <= lstart_d;
      llen_q   <= llen_d;
      used_q   <= used_d;
      pend_q   <= pend_d;
    end
  end

  // An escape can only start after the first character was classified
  `DNTW_ASSERT(a_escape_after_first, (mode_q == MODE_NORMAL) || (trk_q == TRK_MORE), "escape mode before any label character")
  // A reserved length slot always opens an empty label
  `DNTW_ASSERT(a_pending_empty_label, !pend_q || (llen_q == 8'd0), "pending slot with nonzero label length")
  // The first error sticks until the end marker
  `DNTW_ASSERT_NEXT(a_error_sticky, fire_i && !eon_i && (err_q != ST_OK), $stable(err_q), "error code changed before end of name")

endmodule

`default_nettype wire

FILE: sv/dntw_out.sv
// ----------------------------------------------------------------------------
// dntw_out
// Output register plus a hold slot for the second item of a name's end.
// ----------------------------------------------------------------------------
`default_nettype none

module dntw_out (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        push_i,
  input  wire dntw_pkg::parse_out_t  res_i,
  input  wire                        ready_i,
  output logic                       can_take_o,
  output logic                       valid_o,
  output dntw_pkg::result_t          item_o
);
  import dntw_pkg::*;
  `include "dns_name_text_to_wire_top_macros.svh"

  logic    out_valid_q;
  result_t out_q;
  logic    hold_valid_q;
  result_t hold_q;
  logic    out_free;

  assign out_free   = !out_valid_q || ready_i;
  assign can_take_o = !hold_valid_q && out_free;
  assign valid_o    = out_valid_q;
  assign item_o     = out_q;

  // Advance the hold slot first, then load new items
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      hold_valid_q <= 1'b0;
    end else if (hold_valid_q && out_free) begin
      out_valid_q  <= 1'b1;
      hold_valid_q <= 1'b0;
    end else if (push_i && (res_i.count != 2'd0)) begin
      out_valid_q  <= 1'b1;
      hold_valid_q <= (res_i.count == 2'd2);
    end else if (ready_i) begin
      out_valid_q  <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (hold_valid_q && out_free) begin
      out_q <= hold_q;
    end else if (push_i && (res_i.count != 2'd0)) begin
      out_q  <= res_i.r0;
      hold_q <= res_i.r1;
    end
  end

  // The hold slot only fills behind a valid output
  `DNTW_ASSERT(a_hold_behind_out, !hold_valid_q || out_valid_q,
               "hold slot valid with empty output")
  // The held item is always the closing item of a name
  `DNTW_ASSERT(a_hold_is_last, !hold_valid_q || hold_q.last,
               "held item is not the last of its name")
  // Error status only appears on a last item without a write
  `DNTW_ASSERT(a_error_on_last,
               !out_valid_q || (out_q.status == ST_OK) || (out_q.last && !out_q.we),
               "error status on a non-final or writing item")

endmodule

`default_nettype wire

FILE: sv/dns_name_text_to_wire_top.sv
// ----------------------------------------------------------------------------
// dns_name_text_to_wire_top
// DNS name converter: presentation-form characters in, wire-format byte
// writes out.
// ----------------------------------------------------------------------------
// Takes one character per cycle while the output side accepts, and emits
// offset/byte writes that build the wire-format name; the end marker (tlast)
// yields the length/terminator writes and a status on the item with tlast
// set. Each input item passes the input register, then the result register.
// An end marker that closes a name with a non-empty last label makes two
// output items; the second waits in a one-entry hold slot, which holds off
// further items carrying output until it moves on. Output tdata bits other
// than the listed fields are zero.
`default_nettype none

module dns_name_text_to_wire_top (
  input  wire         clk_i,
  input  wire         rst_ni,
  // slave side
  input  wire         s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  wire  [7:0]  s_axis_tdata_i,   // [7:0] character
  input  wire         s_axis_tlast_i,   // end_of_name
  // master side
  output logic        m_axis_tvalid_o,
  input  wire         m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [0] write_enable, [8:1] offset,
                                        // [16:9] wire_byte, [24:17] name_length
  output logic        m_axis_tlast_o,   // last
  output logic [1:0]  m_axis_tuser_o    // [1:0] status
);
  import dntw_pkg::*;

  logic       in_valid_q;
  logic [7:0] in_char_q;
  logic       in_eon_q;
  logic       fire;
  logic       can_take;
  parse_out_t res;
  result_t    item;

  // Fire when the item makes no output or the output side can take it
  assign fire            = in_valid_q && ((res.count == 2'd0) || can_take);
  assign s_axis_tready_o = !in_valid_q || fire;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_char_q <= s_axis_tdata_i;
      in_eon_q  <= s_axis_tlast_i;
    end
  end

  dntw_parse u_parse (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .char_i (in_char_q),
    .eon_i  (in_eon_q),
    .res_o  (res)
  );

  dntw_out u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (fire),
    .res_i      (res),
    .ready_i    (m_axis_tready_i),
    .can_take_o (can_take),
    .valid_o    (m_axis_tvalid_o),
    .item_o     (item)
  );

  // Pack the output item
  assign m_axis_tdata_o = {7'd0, item.name_len, item.wbyte, item.offset, item.we};
  assign m_axis_tlast_o = item.last;
  assign m_axis_tuser_o = item.status;

endmodule

`default_nettype wire
